// ----- design/hga_pkg.sv -----
package hga_pkg;

   // Fibonacci hashing multiplier, 2^32 divided by the golden ratio
   localparam logic [31:0] FIB_MULT = 32'd2654435769;

   // Result status codes
   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // One hash table slot as stored in the table memory
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] count;
      logic [31:0] sum;
      logic [31:0] square_sum;
   } slot_entry_type;

endpackage

// ----- design/hga_ram.sv -----
module hga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry; register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/hash_group_aggregator.sv -----
// Group-by aggregator over an open-addressed hash table of 2^TABLE_BITS slots held in one
// single-port-read, single-port-write RAM. Each request (key, value) is hashed by Fibonacci
// multiplication and probed linearly; a found group has its count, sum and sum of squares
// advanced, an empty slot is claimed, and a table with every slot taken and no match drops
// the request with status full. A request whose group sits at its home slot is hashed and
// needs one RAM read and write-back; each further probe takes another read, since the
// table RAM gives one read per cycle. A table full of other keys is probed at every slot
// before the request is dropped. After reset a clearing pass writes every slot empty, one
// per cycle, while requests are stalled.
module hash_group_aggregator import hga_pkg::*; #(
   parameter int TABLE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [31:0]    req_key,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TABLE_BITS-1:0] rsp_slot,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_group_count,
   output logic signed [31:0]    rsp_group_sum,
   output logic signed [31:0]    rsp_group_square_sum
);

   localparam int TABLE_DEPTH = 1 << TABLE_BITS;
   localparam int ENTRY_BITS  = $bits(slot_entry_type);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [TABLE_BITS-1:0] clr_ff, clr_in;
   logic [TABLE_BITS-1:0] probe_ff, probe_in;
   logic [TABLE_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]           key_ff, key_in;
   logic [31:0]           value_ff, value_in;
   logic [31:0]           square_ff, square_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TABLE_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_count_ff, rsp_count_in;
   logic [31:0]           rsp_sum_ff, rsp_sum_in;
   logic [31:0]           rsp_square_ff, rsp_square_in;

   logic [63:0]           hash_prod;
   logic [63:0]           square_prod;
   logic [TABLE_BITS-1:0] home_slot;

   logic                  wr_en;
   logic [TABLE_BITS-1:0] wr_addr;
   slot_entry_type        wr_entry;
   logic [TABLE_BITS-1:0] rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   slot_entry_type        rd_entry;

   logic                  slot_empty;
   logic                  key_match;
   logic                  probe_last;
   logic                  probe_done;
   logic                  out_free;
   logic                  finish;
   logic                  accept;

   // Hash and square the incoming request
   assign hash_prod   = 64'(unsigned'(req_key)) * 64'(FIB_MULT);
   assign square_prod = 64'(unsigned'(req_value)) * 64'(unsigned'(req_value));
   assign home_slot   = hash_prod[31 -: TABLE_BITS];

   // Table memory
   hga_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = slot_entry_type'(rd_data);

   // Judge the slot just read
   assign slot_empty = !rd_entry.valid;
   assign key_match  = rd_entry.valid && (rd_entry.key == key_ff);
   assign probe_last = &cnt_ff;
   assign probe_done = slot_empty || key_match || probe_last;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == ST_CHECK) && probe_done && out_free;

   assign req_stall = !((state_ff == ST_IDLE) || finish);
   assign accept    = req_valid && !req_stall;

   // Sequence clearing, probing and write-back
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      probe_in      = probe_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      square_in     = square_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_square_in = rsp_square_ff;
      rd_addr       = probe_ff;
      wr_en         = 1'b0;
      wr_addr       = probe_ff;
      wr_entry      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!probe_done) begin
               // advance to the next slot, wrapping at the table end
               probe_in = probe_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               rd_addr  = probe_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               priority if (slot_empty) begin
                  // claim the empty slot for a new group
                  wr_en               = 1'b1;
                  wr_entry.valid      = 1'b1;
                  wr_entry.key        = key_ff;
                  wr_entry.count      = 32'd1;
                  wr_entry.sum        = value_ff;
                  wr_entry.square_sum = square_ff;
                  rsp_slot_in         = probe_ff;
                  rsp_status_in       = STATUS_INSERTED;
                  rsp_count_in        = 32'd1;
                  rsp_sum_in          = value_ff;
                  rsp_square_in       = square_ff;
               end else if (key_match) begin
                  // fold the value into the existing group
                  wr_en               = 1'b1;
                  wr_entry.valid      = 1'b1;
                  wr_entry.key        = key_ff;
                  wr_entry.count      = rd_entry.count + 32'd1;
                  wr_entry.sum        = rd_entry.sum + value_ff;
                  wr_entry.square_sum = rd_entry.square_sum + square_ff;
                  rsp_slot_in         = probe_ff;
                  rsp_status_in       = STATUS_UPDATED;
                  rsp_count_in        = wr_entry.count;
                  rsp_sum_in          = wr_entry.sum;
                  rsp_square_in       = wr_entry.square_sum;
               end else begin
                  // every slot taken by other keys: drop the request
                  rsp_slot_in   = '0;
                  rsp_status_in = STATUS_FULL;
                  rsp_count_in  = '0;
                  rsp_sum_in    = '0;
                  rsp_square_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take a new request; the write-back above lands before its first read
      if (accept) begin
         key_in    = req_key;
         value_in  = req_value;
         square_in = square_prod[31:0];
         probe_in  = home_slot;
         cnt_in    = '0;
         state_in  = ST_READ;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      cnt_ff        <= cnt_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      square_ff     <= square_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_square_ff <= rsp_square_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_group_count      = rsp_count_ff;
   assign rsp_group_sum        = signed'(rsp_sum_ff);
   assign rsp_group_square_sum = signed'(rsp_square_ff);

endmodule

// ----- design/hga_checker.sv -----
module hga_checker import hga_pkg::*; #(
   parameter int SLOT_BITS = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [SLOT_BITS-1:0] rsp_slot,
   input logic [1:0]           rsp_status,
   input logic [31:0]          rsp_group_count
);

   // Hold off requests as the clearing pass begins after reset is released
   assert property (@(posedge clock) $past(reset) && !reset |-> req_stall)
      else $error("request accepted during the clearing pass");

   // A dropped request reports slot zero and a zero group count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_slot == '0) && (rsp_group_count == '0))
      else $error("full-table response carries non-zero fields");

   // A freshly inserted group holds exactly one item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_INSERTED) |-> (rsp_group_count == 32'd1))
      else $error("inserted group count is not one");

   // A stalled response stays presented
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

endmodule

bind hash_group_aggregator hga_checker #(.SLOT_BITS(TABLE_BITS)) u_hga_checker (.*);

// ----- bench/group_aggregate_checker.sv -----
`timescale 1ns / 100ps

// Watch both channels, keep a shadow copy of the group table, and check every
// result against the oldest outstanding prediction.
module group_aggregate_checker import hga_pkg::*; #(
   parameter int TABLE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [31:0]           req_key,
   input  logic [31:0]           req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [TABLE_BITS-1:0] rsp_slot,
   input  logic [1:0]            rsp_status,
   input  logic [31:0]           rsp_group_count,
   input  logic [31:0]           rsp_group_sum,
   input  logic [31:0]           rsp_group_square_sum,
   output int                    fail_count,
   output int                    results_pending
);

   localparam int DEPTH = 1 << TABLE_BITS;

   typedef struct {
      logic [TABLE_BITS-1:0] slot;
      logic [1:0]            status;
      logic [31:0]           count;
      logic [31:0]           sum;
      logic [31:0]           square_sum;
   } group_result_type;

   // Shadow of the hash table
   bit          group_valid      [DEPTH];
   logic [31:0] group_key        [DEPTH];
   logic [31:0] group_count      [DEPTH];
   logic [31:0] group_sum        [DEPTH];
   logic [31:0] group_square_sum [DEPTH];

   group_result_type expected_groups [$];

   // Hash the key, probe linearly with wrap-around, and update or claim a slot
   task automatic aggregate_request(input logic [31:0] key, input logic [31:0] value,
                                    output group_result_type res);
      logic [31:0] product;
      logic [31:0] square;
      int unsigned idx;
      bit          done;
      product        = key * FIB_MULT;
      square         = value * value;
      idx            = product >> (32 - TABLE_BITS);
      done           = 1'b0;
      res.slot       = '0;
      res.status     = STATUS_FULL;
      res.count      = '0;
      res.sum        = '0;
      res.square_sum = '0;
      for (int probe = 0; probe < DEPTH && !done; probe++) begin
         if (!group_valid[idx]) begin
            group_valid[idx]      = 1'b1;
            group_key[idx]        = key;
            group_count[idx]      = 32'd1;
            group_sum[idx]        = value;
            group_square_sum[idx] = square;
            res.status            = STATUS_INSERTED;
            done = 1'b1;
         end else if (group_key[idx] == key) begin
            group_count[idx]      = group_count[idx] + 32'd1;
            group_sum[idx]        = group_sum[idx] + value;
            group_square_sum[idx] = group_square_sum[idx] + square;
            res.status            = STATUS_UPDATED;
            done = 1'b1;
         end else begin
            idx = (idx + 1) % DEPTH;
         end
         if (done) begin
            res.slot       = idx[TABLE_BITS-1:0];
            res.count      = group_count[idx];
            res.sum        = group_sum[idx];
            res.square_sum = group_square_sum[idx];
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Predict on each accepted request, compare on each accepted result
   always @(posedge clock) begin : track
      group_result_type want;
      if (reset) begin
         foreach (group_valid[i]) group_valid[i] = 1'b0;
         expected_groups.delete();
      end else begin
         if (req_valid && !req_stall) begin
            aggregate_request(req_key, req_value, want);
            expected_groups.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_groups.size() == 0) begin
               $error("unexpected result: slot %0d, status %0d", rsp_slot, rsp_status);
               fail_count++;
            end else begin
               want = expected_groups.pop_front();
               compare_field("slot", 32'(want.slot), 32'(rsp_slot));
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("group_count", want.count, rsp_group_count);
               compare_field("group_sum", want.sum, rsp_group_sum);
               compare_field("group_square_sum", want.square_sum, rsp_group_square_sum);
            end
         end
      end
      results_pending = expected_groups.size();
   end

endmodule

// ----- bench/tb_hash_group_aggregator.sv -----
`timescale 1ns / 100ps

module tb_hash_group_aggregator;
   import hga_pkg::*;

   localparam int TABLE_BITS         = 12;
   localparam int DEPTH              = 1 << TABLE_BITS;
   localparam int CYCLE_LIMIT        = 2_000_000;
   localparam int DRAIN_CYCLES       = 8;
   localparam int RANDOM_PHASE_ITEMS = 275;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [31:0]    req_key;
   logic signed [31:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TABLE_BITS-1:0] rsp_slot;
   logic [1:0]            rsp_status;
   logic [31:0]           rsp_group_count;
   logic signed [31:0]    rsp_group_sum;
   logic signed [31:0]    rsp_group_square_sum;

   int          fail_count;
   int          results_pending;
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          cycle_count;
   logic [31:0] hash_inverse;
   logic [31:0] known_keys [$];

   hash_group_aggregator #(
      .TABLE_BITS(TABLE_BITS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key             (req_key),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_slot            (rsp_slot),
      .rsp_status          (rsp_status),
      .rsp_group_count     (rsp_group_count),
      .rsp_group_sum       (rsp_group_sum),
      .rsp_group_square_sum(rsp_group_square_sum)
   );

   group_aggregate_checker #(
      .TABLE_BITS(TABLE_BITS)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key             (req_key),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_slot            (rsp_slot),
      .rsp_status          (rsp_status),
      .rsp_group_count     (rsp_group_count),
      .rsp_group_sum       (rsp_group_sum),
      .rsp_group_square_sum(rsp_group_square_sum),
      .fail_count          (fail_count),
      .results_pending     (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Newton iteration for the inverse of an odd number mod 2^32
   function automatic logic [31:0] odd_inverse(input logic [31:0] m);
      logic [31:0] x;
      x = m;
      repeat (5) x = x * (32'd2 - m * x);
      return x;
   endfunction

   // Build a key whose hash lands on the given home slot
   function automatic logic [31:0] key_for_home(input int unsigned home);
      logic [31:0] product;
      product = (32'(home) << (32 - TABLE_BITS))
              | ($urandom & ((32'd1 << (32 - TABLE_BITS)) - 32'd1));
      return product * hash_inverse;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(3))
         0: return 32'($urandom_range(255));
         1: return ~32'($urandom_range(255));
         2: begin
            case ($urandom_range(3))
               0:       return 32'h7fff_ffff;
               1:       return 32'h8000_0000;
               2:       return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Most often revisit known groups, else crowd a few home slots, else anything
   function automatic logic [31:0] random_key();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45 && known_keys.size() > 0)
         return known_keys[$urandom_range(known_keys.size() - 1)];
      if (pick < 53)
         return key_for_home(DEPTH - 1 - $urandom_range(3));
      if (pick < 65)
         return key_for_home($urandom_range(31) * (DEPTH / 32));
      return $urandom;
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic push_request(input logic [31:0] key, input logic [31:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] key;
      logic [31:0] wrap_key;
      logic [31:0] chain_key;
      req_valid    = 1'b0;
      req_key      = '0;
      req_value    = '0;
      reset        = 1'b1;
      hash_inverse = odd_inverse(FIB_MULT);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Extremes of key and value, repeated groups and wrapping sums
      push_request(32'h0000_0000, 32'h0000_0000);
      push_request(32'h0000_0000, 32'h7fff_ffff);
      push_request(32'h0000_0000, 32'h7fff_ffff);
      push_request(32'hffff_ffff, 32'h8000_0000);
      push_request(32'hffff_ffff, 32'hffff_ffff);
      push_request(32'h8000_0000, 32'h8000_0000);
      push_request(32'h7fff_ffff, 32'h7fff_ffff);
      push_request(32'h7fff_ffff, 32'h0000_0001);

      // Pile up on the last slot so the probe wraps to the first slots
      push_request(key_for_home(DEPTH - 1), 32'd12345);
      push_request(key_for_home(DEPTH - 1), 32'hffff_fff9);
      wrap_key = key_for_home(DEPTH - 1);
      push_request(wrap_key, 32'h0000_0000);
      push_request(wrap_key, 32'h8000_0000);

      // Collision chain at slot 100, then hit the middle entry
      push_request(key_for_home(100), 32'd1);
      chain_key = key_for_home(100);
      push_request(chain_key, 32'd2);
      push_request(key_for_home(100), 32'd3);
      push_request(chain_key, 32'hffff_ffff);
      push_request(32'hffff_ffff, 32'h0000_0000);

      known_keys = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     wrap_key, chain_key};

      // Random requests under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 69; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin req_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         repeat (RANDOM_PHASE_ITEMS) begin
            key = random_key();
            known_keys.push_back(key);
            push_request(key, random_value());
         end
      end

      // Fresh keys mixed with known groups, then the crowded last slot
      req_idle_pct  = 69;
      rsp_stall_pct = 0;
      repeat (4) begin
         push_request($urandom, random_value());
         push_request(known_keys[$urandom_range(known_keys.size() - 1)], random_value());
      end
      push_request(key_for_home(DEPTH - 1), 32'h7fff_ffff);
      push_request(32'hffff_ffff, random_value());

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/hga_pkg.sv
design/hga_ram.sv
design/hash_group_aggregator.sv
design/hga_checker.sv
bench/group_aggregate_checker.sv
bench/tb_hash_group_aggregator.sv
